@@ sv/ledenc_pkg.sv @@
// ledenc_pkg: shared constants, register indexes and types of the led bit symbol encoder
// no dependencies; imported by the interfaces and all modules of the block

package ledenc_pkg;

   localparam int MAX_LEDS  = 1024;
   localparam int LED_W     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int DUR_W     = 15;
   localparam int BYTE_W    = 8;
   localparam int HDR_MAX   = 16;
   localparam int HDR_W     = 5;
   localparam int IDX_W     = $clog2(HDR_MAX);
   localparam int BIG_W     = 2;
   localparam int KIND_W    = 2;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GAP    = 2'd2;

   typedef enum logic [2:0] {
      REG_ZERO_HIGH  = 3'd0,
      REG_ZERO_LOW   = 3'd1,
      REG_ONE_HIGH   = 3'd2,
      REG_ONE_LOW    = 3'd3,
      REG_GAP_HIGH   = 3'd4,
      REG_GAP_LOW    = 3'd5,
      REG_HDR_WIDTH  = 3'd6,
      REG_FOUR_CHAN  = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [DUR_W-1:0] zero_high;
      logic [DUR_W-1:0] zero_low;
      logic [DUR_W-1:0] one_high;
      logic [DUR_W-1:0] one_low;
      logic [DUR_W-1:0] gap_high;
      logic [DUR_W-1:0] gap_low;
      logic [HDR_W-1:0] header_width;
      logic             four_channels;
   } cfg_type;

   // everything the symbol sequencer needs to expand one byte
   typedef struct packed {
      logic [BYTE_W-1:0]  pixel;
      logic [HDR_MAX-1:0] hdr_bits;
      logic [HDR_W-1:0]   hdr_len;
      logic               gap_pre;
      logic               gap_post;
      logic               last;
   } item_type;

endpackage

@@ sv/ledenc_if.sv @@
// ledenc_req_if / ledenc_rsp_if: valid/ready channels of the led bit symbol encoder
// depends on ledenc_pkg for field widths

interface ledenc_req_if import ledenc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_byte;
   logic              frame_last;

   modport source (output valid, output pixel_byte, output frame_last, input ready);
   modport sink   (input valid, input pixel_byte, input frame_last, output ready);
endinterface

interface ledenc_rsp_if import ledenc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DUR_W-1:0]  high_ticks;
   logic [DUR_W-1:0]  low_ticks;
   logic [KIND_W-1:0] symbol_kind;
   logic              run_last;
   logic              frame_end;

   modport source (output valid, output high_ticks, output low_ticks, output symbol_kind,
                   output run_last, output frame_end, input ready);
   modport sink   (input valid, input high_ticks, input low_ticks, input symbol_kind,
                   input run_last, input frame_end, output ready);
endinterface

@@ sv/ledenc_csr.sv @@
// ledenc_csr: apb-style configuration registers of the led bit symbol encoder
// depends on ledenc_pkg

module ledenc_csr import ledenc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ZERO_HIGH: cfg_in.zero_high     = pwdata[DUR_W-1:0];
            REG_ZERO_LOW:  cfg_in.zero_low      = pwdata[DUR_W-1:0];
            REG_ONE_HIGH:  cfg_in.one_high      = pwdata[DUR_W-1:0];
            REG_ONE_LOW:   cfg_in.one_low       = pwdata[DUR_W-1:0];
            REG_GAP_HIGH:  cfg_in.gap_high      = pwdata[DUR_W-1:0];
            REG_GAP_LOW:   cfg_in.gap_low       = pwdata[DUR_W-1:0];
            REG_HDR_WIDTH: cfg_in.header_width  = pwdata[HDR_W-1:0];
            REG_FOUR_CHAN: cfg_in.four_channels = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ZERO_HIGH: prdata = CSR_DW'(cfg_ff.zero_high);
         REG_ZERO_LOW:  prdata = CSR_DW'(cfg_ff.zero_low);
         REG_ONE_HIGH:  prdata = CSR_DW'(cfg_ff.one_high);
         REG_ONE_LOW:   prdata = CSR_DW'(cfg_ff.one_low);
         REG_GAP_HIGH:  prdata = CSR_DW'(cfg_ff.gap_high);
         REG_GAP_LOW:   prdata = CSR_DW'(cfg_ff.gap_low);
         REG_HDR_WIDTH: prdata = CSR_DW'(cfg_ff.header_width);
         REG_FOUR_CHAN: prdata = CSR_DW'(cfg_ff.four_channels);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/ledenc_plan.sv @@
// ledenc_plan: frame position tracking (byte in group, led index) and item planning
// depends on ledenc_pkg; feeds ledenc_seq with one item_type per accepted byte

module ledenc_plan import ledenc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [BYTE_W-1:0] pixel_byte,
   input  logic              frame_last,
   output item_type          item
);

   logic [BIG_W-1:0] big_ff, big_in;
   logic [LED_W-1:0] led_ff, led_in;
   logic             started_ff, started_in;

   logic             gap_en;
   logic             opens_led;
   logic [HDR_W-1:0] hw_clamped;
   logic [BIG_W:0]   big_inc;
   logic [BIG_W:0]   group_size;
   logic [LED_W:0]   led_inc;

   assign gap_en     = (cfg.gap_high != '0) || (cfg.gap_low != '0);
   assign opens_led  = (big_ff == '0);
   assign hw_clamped = (cfg.header_width > HDR_W'(HDR_MAX)) ? HDR_W'(HDR_MAX)
                                                              : cfg.header_width;
   assign group_size = cfg.four_channels ? (BIG_W+1)'(4) : (BIG_W+1)'(3);
   assign big_inc    = {1'b0, big_ff} + 1'b1;
   assign led_inc    = {1'b0, led_ff} + 1'b1;

   always_comb begin
      item.pixel    = pixel_byte;
      item.hdr_bits = HDR_MAX'(led_ff);
      item.hdr_len  = opens_led ? hw_clamped : '0;
      item.gap_pre  = opens_led && started_ff && gap_en;
      item.gap_post = frame_last && gap_en;
      item.last     = frame_last;
   end

   always_comb begin
      big_in     = big_ff;
      led_in     = led_ff;
      started_in = started_ff;
      if (accept) begin
         // a byte past the group size (size changed mid frame) still closes the group
         big_in = (big_inc >= group_size) ? '0 : big_inc[BIG_W-1:0];
         if (opens_led) begin
            started_in = 1'b1;
            led_in     = (led_inc >= (LED_W+1)'(MAX_LEDS)) ? '0 : led_inc[LED_W-1:0];
         end
         if (frame_last) begin
            big_in     = '0;
            led_in     = '0;
            started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_ff     <= '0;
         led_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         big_ff     <= big_in;
         led_ff     <= led_in;
         started_ff <= started_in;
      end
   end

endmodule

@@ sv/ledenc_seq.sv @@
// ledenc_seq: symbol sequencer, expands one planned item into gap, header and data symbols
// depends on ledenc_pkg; holds the item register and the result register

module ledenc_seq import ledenc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  item_type          item_in,
   input  logic              load,
   output logic              take_ok,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DUR_W-1:0]  out_high,
   output logic [DUR_W-1:0]  out_low,
   output logic [KIND_W-1:0] out_kind,
   output logic              out_run_last,
   output logic              out_frame_end
);

   typedef enum logic [3:0] {
      PH_GAP  = 4'b0001,
      PH_HDR  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_END  = 4'b1000
   } phase_type;

   item_type          item_ff, item_next_in;
   logic              busy_ff, busy_in;
   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              ovalid_ff, ovalid_in;
   logic [DUR_W-1:0]  ohigh_ff, ohigh_in;
   logic [DUR_W-1:0]  olow_ff, olow_in;
   logic [KIND_W-1:0] okind_ff, okind_in;
   logic              olast_ff, olast_in;
   logic              oend_ff, oend_in;

   logic              advance;
   logic              sym_bit;
   logic              sym_last;
   logic              hdr_done;
   logic              data_done;
   logic [DUR_W-1:0]  sym_high, sym_low;
   logic [KIND_W-1:0] sym_kind;
   phase_type         start_phase;
   phase_type         after_gap;

   assign advance   = busy_ff && (!ovalid_ff || out_ready);
   assign hdr_done  = (idx_ff == IDX_W'(item_ff.hdr_len - 1'b1));
   assign data_done = (idx_ff[2:0] == 3'd7);
   assign after_gap = (item_ff.hdr_len != '0) ? PH_HDR : PH_DATA;
   assign take_ok   = !busy_ff || (advance && sym_last);

   always_comb begin
      if (item_in.gap_pre) begin
         start_phase = PH_GAP;
      end else if (item_in.hdr_len != '0) begin
         start_phase = PH_HDR;
      end else begin
         start_phase = PH_DATA;
      end
   end

   // current symbol
   always_comb begin
      sym_bit  = 1'b0;
      sym_last = 1'b0;
      sym_kind = KIND_DATA;
      unique case (phase_ff)
         PH_GAP: begin
            sym_kind = KIND_GAP;
         end
         PH_HDR: begin
            sym_kind = KIND_HEADER;
            sym_bit  = item_ff.hdr_bits[idx_ff];
         end
         PH_DATA: begin
            sym_bit  = item_ff.pixel[idx_ff[2:0]];
            sym_last = data_done && !item_ff.gap_post;
         end
         PH_END: begin
            sym_kind = KIND_GAP;
            sym_last = 1'b1;
         end
         default: begin
            sym_kind = KIND_DATA;
         end
      endcase
      if (sym_kind == KIND_GAP) begin
         sym_high = cfg.gap_high;
         sym_low  = cfg.gap_low;
      end else if (sym_bit) begin
         sym_high = cfg.one_high;
         sym_low  = cfg.one_low;
      end else begin
         sym_high = cfg.zero_high;
         sym_low  = cfg.zero_low;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      item_next_in = item_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_GAP: begin
               phase_in = after_gap;
               idx_in   = '0;
            end
            PH_HDR: begin
               if (hdr_done) begin
                  phase_in = PH_DATA;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_DATA: begin
               if (data_done) begin
                  phase_in = PH_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_END: begin
               phase_in = PH_END;
            end
            default: begin
               phase_in = PH_DATA;
            end
         endcase
         if (sym_last) begin
            busy_in = 1'b0;
         end
      end
      // a new transaction is loaded while idle, or in the same cycle the previous one issues its last symbol
      if (load) begin
         busy_in      = 1'b1;
         item_next_in = item_in;
         phase_in     = start_phase;
         idx_in       = '0;
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      ohigh_in  = ohigh_ff;
      olow_in   = olow_ff;
      okind_in  = okind_ff;
      olast_in  = olast_ff;
      oend_in   = oend_ff;
      if (advance) begin
         ovalid_in = 1'b1;
         ohigh_in  = sym_high;
         olow_in   = sym_low;
         okind_in  = sym_kind;
         olast_in  = sym_last;
         oend_in   = sym_last && item_ff.last;
      end else if (out_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         phase_ff  <= PH_DATA;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_next_in;
      ohigh_ff <= ohigh_in;
      olow_ff  <= olow_in;
      okind_ff <= okind_in;
      olast_ff <= olast_in;
      oend_ff  <= oend_in;
   end

   assign out_valid     = ovalid_ff;
   assign out_high      = ohigh_ff;
   assign out_low       = olow_ff;
   assign out_kind      = okind_ff;
   assign out_run_last  = olast_ff;
   assign out_frame_end = oend_ff;

endmodule

@@ sv/addressed_led_bit_symbol_encoder.sv @@
// addressed_led_bit_symbol_encoder: top level of the led bit symbol encoder
// depends on ledenc_pkg, ledenc_if, ledenc_csr, ledenc_plan, ledenc_seq
//
//   port      direction  kind             carries
//   req_bus   in         valid/ready      pixel_byte, frame_last
//   rsp_bus   out        valid/ready      high_ticks, low_ticks, symbol_kind, run_last, frame_end
//   csr_*     in/out     apb-style        eight configuration registers at 4*index
//
// one symbol per cycle enters the result register unless rsp_bus stalls; a byte gives 8 to 26
// symbols: 8 data bits, header_width bits if it opens an led, a gap before each led but the
// first and one at frame end if a gap time is set. the sequencer is the only shared unit; the
// next byte is taken as the last symbol issues. reset is synchronous and clears the registers,
// frame position and led index. a stall on rsp_bus holds the result register and the sequencer;
// req_bus waits until the last symbol of the current byte has moved into the result register.

module addressed_led_bit_symbol_encoder import ledenc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ledenc_req_if.sink        req_bus,
   ledenc_rsp_if.source      rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type  cfg;
   item_type item;
   logic     take_ok;
   logic     accept;

   assign req_bus.ready = take_ok;
   assign accept        = req_bus.valid && take_ok;

   ledenc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ledenc_plan u_plan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .pixel_byte (req_bus.pixel_byte),
      .frame_last (req_bus.frame_last),
      .item       (item)
   );

   ledenc_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_in       (item),
      .load          (accept),
      .take_ok       (take_ok),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_high      (rsp_bus.high_ticks),
      .out_low       (rsp_bus.low_ticks),
      .out_kind      (rsp_bus.symbol_kind),
      .out_run_last  (rsp_bus.run_last),
      .out_frame_end (rsp_bus.frame_end)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for addressed_led_bit_symbol_encoder, pixel bytes in, pulse symbols out
// depends on ledenc_pkg, the ledenc_req_if / ledenc_rsp_if channels and the encoder rtl

module tb;
   import ledenc_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic              last;
   } pixel_txn_type;

   typedef struct packed {
      logic [DUR_W-1:0]  high_ticks;
      logic [DUR_W-1:0]  low_ticks;
      logic [KIND_W-1:0] kind;
      logic              run_last;
      logic              frame_end;
   } symbol_txn_type;

   localparam int SYMBOL_LATENCY = 30;
   localparam int RANDOM_BYTES   = 320;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   ledenc_req_if req_bus ();
   ledenc_rsp_if rsp_bus ();

   addressed_led_bit_symbol_encoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pixel_txn_type  bytes_to_send[$];
   symbol_txn_type symbols_due[$];
   pixel_txn_type  byte_on_bus;
   symbol_txn_type seen_symbol;
   symbol_txn_type due_symbol;
   int unsigned send_hold    = 0;
   int unsigned stall_hold   = 0;
   int unsigned bad_symbols  = 0;
   int unsigned bytes_queued = 0;
   bit          src_steady   = 1'b0;
   bit          snk_steady   = 1'b0;

   // shadow of the encoder registers and of its position in the frame
   cfg_type     enc_cfg    = '0;
   int unsigned pos_in_led = 0;
   int unsigned led_index  = 0;
   bit          frame_open = 1'b0;

   always #5 clock = ~clock;

   function automatic int unsigned draw_wait(input bit steady);
      if (steady || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic symbol_txn_type make_symbol(input logic [DUR_W-1:0] hi,
                                                   input logic [DUR_W-1:0] lo,
                                                   input logic [KIND_W-1:0] kind);
      symbol_txn_type s;
      s.high_ticks = hi;
      s.low_ticks  = lo;
      s.kind       = kind;
      s.run_last   = 1'b0;
      s.frame_end  = 1'b0;
      return s;
   endfunction

   function automatic symbol_txn_type bit_symbol(input bit one, input logic [KIND_W-1:0] kind);
      if (one)
         return make_symbol(enc_cfg.one_high, enc_cfg.one_low, kind);
      return make_symbol(enc_cfg.zero_high, enc_cfg.zero_low, kind);
   endfunction

   function automatic bit gaps_on();
      return (enc_cfg.gap_high != '0) || (enc_cfg.gap_low != '0);
   endfunction

   function automatic string show(input symbol_txn_type s);
      return $sformatf("hi=%0d lo=%0d kind=%0d run_last=%0b frame_end=%0b",
                       s.high_ticks, s.low_ticks, s.kind, s.run_last, s.frame_end);
   endfunction

   // symbols that one accepted pixel byte turns into
   function automatic void expand_byte(input pixel_txn_type txn);
      symbol_txn_type burst[$];
      int unsigned hdr_bits;
      int unsigned group;
      group = enc_cfg.four_channels ? 4 : 3;
      if (pos_in_led == 0) begin
         hdr_bits = (enc_cfg.header_width > HDR_MAX) ? HDR_MAX : enc_cfg.header_width;
         if (frame_open && gaps_on())
            burst.push_back(make_symbol(enc_cfg.gap_high, enc_cfg.gap_low, KIND_GAP));
         for (int i = 0; i < hdr_bits; i++)
            burst.push_back(bit_symbol(bit'((led_index >> i) & 1), KIND_HEADER));
         frame_open = 1'b1;
         led_index  = (led_index + 1 >= MAX_LEDS) ? 0 : led_index + 1;
      end
      for (int i = 0; i < BYTE_W; i++)
         burst.push_back(bit_symbol(txn.pixel[i], KIND_DATA));
      // a byte past the group size still closes the group
      pos_in_led = (pos_in_led + 1 >= group) ? 0 : pos_in_led + 1;
      if (txn.last) begin
         if (gaps_on())
            burst.push_back(make_symbol(enc_cfg.gap_high, enc_cfg.gap_low, KIND_GAP));
         burst[burst.size() - 1].frame_end = 1'b1;
         pos_in_led = 0;
         led_index  = 0;
         frame_open = 1'b0;
      end
      burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i])
         symbols_due.push_back(burst[i]);
   endfunction

   // pixel byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.pixel_byte <= '0;
         req_bus.frame_last <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expand_byte(byte_on_bus);
            send_hold = draw_wait(src_steady);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_bus.valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
               byte_on_bus = bytes_to_send.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.pixel_byte <= byte_on_bus.pixel;
               req_bus.frame_last <= byte_on_bus.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // symbol monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_symbol = {rsp_bus.high_ticks, rsp_bus.low_ticks, rsp_bus.symbol_kind,
                           rsp_bus.run_last, rsp_bus.frame_end};
            if (symbols_due.size() == 0) begin
               bad_symbols++;
               if (bad_symbols <= 10)
                  $display("%0t: symbol with no transaction pending: %s", $time,
                           show(seen_symbol));
            end else begin
               due_symbol = symbols_due.pop_front();
               if (seen_symbol !== due_symbol) begin
                  bad_symbols++;
                  if (bad_symbols <= 10)
                     $display("%0t: symbol mismatch\n   expected %s\n   actual   %s", $time,
                              show(due_symbol), show(seen_symbol));
               end
            end
            stall_hold = draw_wait(snk_steady);
         end
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ZERO_HIGH: enc_cfg.zero_high     = value[DUR_W-1:0];
         REG_ZERO_LOW:  enc_cfg.zero_low      = value[DUR_W-1:0];
         REG_ONE_HIGH:  enc_cfg.one_high      = value[DUR_W-1:0];
         REG_ONE_LOW:   enc_cfg.one_low       = value[DUR_W-1:0];
         REG_GAP_HIGH:  enc_cfg.gap_high      = value[DUR_W-1:0];
         REG_GAP_LOW:   enc_cfg.gap_low       = value[DUR_W-1:0];
         REG_HDR_WIDTH: enc_cfg.header_width  = value[HDR_W-1:0];
         REG_FOUR_CHAN: enc_cfg.four_channels = value[0];
      endcase
      @(negedge clock);
   endtask

   task automatic load_config(input logic [CSR_DW-1:0] zero_hi, input logic [CSR_DW-1:0] zero_lo,
                              input logic [CSR_DW-1:0] one_hi, input logic [CSR_DW-1:0] one_lo,
                              input logic [CSR_DW-1:0] gap_hi, input logic [CSR_DW-1:0] gap_lo,
                              input logic [CSR_DW-1:0] hdr_width, input logic [CSR_DW-1:0] four);
      csr_write(REG_ZERO_HIGH, zero_hi);
      csr_write(REG_ZERO_LOW, zero_lo);
      csr_write(REG_ONE_HIGH, one_hi);
      csr_write(REG_ONE_LOW, one_lo);
      csr_write(REG_GAP_HIGH, gap_hi);
      csr_write(REG_GAP_LOW, gap_lo);
      csr_write(REG_HDR_WIDTH, hdr_width);
      csr_write(REG_FOUR_CHAN, four);
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] pixel, input bit last);
      pixel_txn_type txn;
      txn.pixel = pixel;
      txn.last  = last;
      bytes_to_send.push_back(txn);
      bytes_queued++;
   endtask

   // block is idle once every byte is taken and every symbol has come out
   task automatic drain();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_bus.valid || symbols_due.size() != 0);
   endtask

   function automatic logic [CSR_DW-1:0] pick_ticks();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'h7FFF;
         2:       return $urandom;   // junk above the duration width
         default: return $urandom_range(1, 32'h7FFF);
      endcase
   endfunction

   initial begin
      logic [CSR_DW-1:0] gap_hi;
      logic [CSR_DW-1:0] gap_lo;
      logic [CSR_DW-1:0] hdr_width;
      int unsigned       target;
      int unsigned       frame_len;
      bit                open_end;

      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers as reset: zero durations, no header, gaps off so frame_end lands on a data bit
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h01, 1'b1);
      drain();

      // duration extremes with junk above the field, full 16-bit header
      load_config(1, 32'h0000_7FFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, HDR_MAX, 0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      drain();

      // header wider than 16, gap with only a low time, four bytes per led
      csr_write(REG_HDR_WIDTH, 31);
      csr_write(REG_GAP_HIGH, 0);
      csr_write(REG_GAP_LOW, 3);
      csr_write(REG_FOUR_CHAN, 1);
      queue_byte(8'h0F, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'h3C, 1'b0);
      drain();

      // group shrinks to three while the fourth byte of the led is still due
      csr_write(REG_FOUR_CHAN, 0);
      csr_write(REG_HDR_WIDTH, 17);
      queue_byte(8'hC3, 1'b0);
      queue_byte(8'h99, 1'b0);
      queue_byte(8'h66, 1'b1);
      drain();

      // one-byte frames, no header
      csr_write(REG_HDR_WIDTH, 0);
      queue_byte(8'hE7, 1'b1);
      queue_byte(8'h18, 1'b1);
      drain();

      target = bytes_queued + RANDOM_BYTES;
      while (bytes_queued < target) begin
         src_steady = ($urandom_range(0, 3) == 0);
         snk_steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: begin gap_hi = '0;           gap_lo = '0;           end
            1: begin gap_hi = pick_ticks(); gap_lo = '0;           end
            2: begin gap_hi = '0;           gap_lo = pick_ticks(); end
            default: begin gap_hi = pick_ticks(); gap_lo = pick_ticks(); end
         endcase
         case ($urandom_range(0, 3))
            0:       hdr_width = '0;
            1:       hdr_width = $urandom_range(HDR_MAX + 1, 31);
            default: hdr_width = $urandom_range(1, HDR_MAX);
         endcase
         load_config(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), gap_hi, gap_lo,
                     hdr_width, $urandom_range(0, 1));
         repeat ($urandom_range(1, 4)) begin
            // mostly whole leds, now and then a ragged frame or one left open
            if ($urandom_range(0, 4) == 0)
               frame_len = $urandom_range(1, 10);
            else
               frame_len = (enc_cfg.four_channels ? 4 : 3) * $urandom_range(1, 6);
            open_end = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < frame_len; k++)
               queue_byte(BYTE_W'($urandom_range(0, 255)), !open_end && k == frame_len - 1);
         end
         drain();
      end

      drain();
      repeat (SYMBOL_LATENCY) @(negedge clock);
      if (bad_symbols == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
sv/ledenc_pkg.sv
sv/ledenc_if.sv
sv/ledenc_csr.sv
sv/ledenc_plan.sv
sv/ledenc_seq.sv
sv/addressed_led_bit_symbol_encoder.sv
tb/tb.sv
